>>> src/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants for the strongly connected components core.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

  // Default graph size
  localparam int unsigned VerticesDefault = 64;

  // Fixed field widths
  localparam int unsigned VertexW = 6;
  localparam int unsigned CompW   = 7;
  localparam int unsigned RowW    = 64;

  typedef logic [VertexW-1:0] vertex_t;
  typedef logic [CompW-1:0]   comp_t;
  typedef logic [RowW-1:0]    row_t;

  // Item operation codes
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_RUN  = 1'b1
  } op_e;

endpackage

`default_nettype wire

>>> src/strongly_connected_components_core.sv
// ----------------------------------------------------------------------------
// strongly_connected_components_core
// Tarjan component search over an adjacency bit matrix with an explicit
// call stack, walked by one small sequencer.
// ----------------------------------------------------------------------------
// A load beat writes one vertex's out-edge row; a row that was never loaded
// reads as empty. A run beat clears all visit marks and searches depth first
// from vertex 0 upward. It returns exactly VERTICES result beats, one per
// vertex, grouped by component in pop order. The search tests one edge bit per
// cycle from a registered copy of the current vertex's row, except that each
// on-stack back edge adds a compare state. The input side stalls for the whole
// run. Output stall holds the sequencer in the pop step, so the search waits
// on it there.
`default_nettype none

module strongly_connected_components_core #(
  parameter int unsigned VERTICES = scc_pkg::VerticesDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire scc_pkg::op_e    op_i,
  input  wire scc_pkg::vertex_t vertex_i,
  input  wire scc_pkg::row_t   row_edges_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output scc_pkg::vertex_t     member_o,
  output scc_pkg::comp_t       component_o,
  output logic                 closes_component_o,
  output logic                 last_o
);

  import scc_pkg::*;

  localparam int unsigned IW = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int unsigned KW = $clog2(VERTICES + 1);

  typedef struct packed {
    logic [IW-1:0] v;
    logic [KW-1:0] k;
    logic [IW-1:0] num;
    logic [IW-1:0] low;
  } frame_t;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_ROOT    = 10'b00_0000_0010,
    ST_ROWRD   = 10'b00_0000_0100,
    ST_SCAN    = 10'b00_0000_1000,
    ST_NUMCMP  = 10'b00_0001_0000,
    ST_POPRD   = 10'b00_0010_0000,
    ST_POPOUT  = 10'b00_0100_0000,
    ST_RET     = 10'b00_1000_0000,
    ST_RESTORE = 10'b01_0000_0000,
    ST_SPARE   = 10'b10_0000_0000
  } state_e;

  // Memories
  logic [VERTICES-1:0] adj_mem  [VERTICES];
  logic [IW-1:0]       vnum_mem [VERTICES];
  logic [IW-1:0]       cstk_mem [VERTICES];
  frame_t              fstk_mem [VERTICES];

  // Control state
  state_e              state_q;
  logic [VERTICES-1:0] adj_vld_q;
  logic [VERTICES-1:0] visited_q;
  logic [VERTICES-1:0] onstk_q;
  logic [IW:0]         ctop_q;
  logic [IW:0]         ftop_q;
  logic [KW-1:0]       root_q;
  logic [IW-1:0]       vcnt_q;
  comp_t               comp_q;
  logic [KW-1:0]       emit_q;
  logic                out_valid_q;

  // Datapath registers
  logic [IW-1:0]       cur_v_q;
  logic [KW-1:0]       cur_k_q;
  logic [IW-1:0]       cur_num_q;
  logic [IW-1:0]       cur_low_q;
  logic [VERTICES-1:0] row_q;
  logic                row_vld_q;
  logic [IW-1:0]       vnum_rd_q;
  logic [IW-1:0]       cstk_rd_q;
  frame_t              frame_rd_q;
  vertex_t             member_q;
  comp_t               comp_out_q;
  logic                closes_q;
  logic                last_q;

  // Decode
  logic          in_fire;
  logic          load_ok;
  logic          out_free;
  logic          root_done;
  logic [IW-1:0] root_idx;
  logic          scan_done;
  logic [IW-1:0] k_idx;
  logic          edge_bit;
  logic [IW-1:0] ctop_idx;
  logic [IW-1:0] ftop_idx;
  logic [IW:0]   ctop_m1;
  logic [IW:0]   ftop_m1;
  logic [KW-1:0] cur_k_inc;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign load_ok    = ({1'b0, vertex_i} < (VertexW + 1)'(VERTICES));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign root_done  = (root_q == KW'(VERTICES));
  assign root_idx   = root_q[IW-1:0];
  assign scan_done  = (cur_k_q == KW'(VERTICES));
  assign k_idx      = cur_k_q[IW-1:0];
  assign edge_bit   = row_vld_q && row_q[k_idx];
  assign ctop_idx   = ctop_q[IW-1:0];
  assign ftop_idx   = ftop_q[IW-1:0];
  assign ctop_m1    = ctop_q - 1'b1;
  assign ftop_m1    = ftop_q - 1'b1;
  assign cur_k_inc  = KW'(cur_k_q + 1'b1);

  // Sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      adj_vld_q   <= '0;
      visited_q   <= '0;
      onstk_q     <= '0;
      ctop_q      <= '0;
      ftop_q      <= '0;
      root_q      <= '0;
      vcnt_q      <= '0;
      comp_q      <= comp_t'(1);
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Mark a row as loaded
      if (in_fire && op_i == OP_LOAD && load_ok) begin
        adj_vld_q[vertex_i[IW-1:0]] <= 1'b1;
      end

      // Output beat register
      if (state_q == ST_POPOUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && op_i == OP_RUN) begin
            visited_q <= '0;
            onstk_q   <= '0;
            ctop_q    <= '0;
            ftop_q    <= '0;
            root_q    <= '0;
            vcnt_q    <= '0;
            comp_q    <= comp_t'(1);
            emit_q    <= '0;
            state_q   <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (root_done) begin
            state_q <= ST_IDLE;
          end else if (visited_q[root_idx]) begin
            root_q <= KW'(root_q + 1'b1);
          end else begin
            visited_q[root_idx] <= 1'b1;
            onstk_q[root_idx]   <= 1'b1;
            ctop_q              <= ctop_q + 1'b1;
            vcnt_q              <= vcnt_q + 1'b1;
            state_q             <= ST_ROWRD;
          end
        end
        ST_ROWRD: begin
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_done) begin
            state_q <= (cur_low_q == cur_num_q) ? ST_POPRD : ST_RET;
          end else if (edge_bit && !visited_q[k_idx]) begin
            // Descend into an unvisited neighbor
            visited_q[k_idx] <= 1'b1;
            onstk_q[k_idx]   <= 1'b1;
            ctop_q           <= ctop_q + 1'b1;
            ftop_q           <= ftop_q + 1'b1;
            vcnt_q           <= vcnt_q + 1'b1;
            state_q          <= ST_ROWRD;
          end else if (edge_bit && onstk_q[k_idx]) begin
            state_q <= ST_NUMCMP;
          end
        end
        ST_NUMCMP: begin
          state_q <= ST_SCAN;
        end
        ST_POPRD: begin
          ctop_q  <= ctop_m1;
          state_q <= ST_POPOUT;
        end
        ST_POPOUT: begin
          if (out_free) begin
            onstk_q[cstk_rd_q] <= 1'b0;
            emit_q             <= KW'(emit_q + 1'b1);
            if (cstk_rd_q == cur_v_q) begin
              comp_q  <= comp_q + 1'b1;
              state_q <= ST_RET;
            end else begin
              state_q <= ST_POPRD;
            end
          end
        end
        ST_RET: begin
          if (ftop_q == '0) begin
            state_q <= ST_ROOT;
          end else begin
            ftop_q  <= ftop_m1;
            state_q <= ST_RESTORE;
          end
        end
        ST_RESTORE: begin
          state_q <= ST_ROWRD;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Memories and datapath
  always_ff @(posedge clk_i) begin
    if (in_fire && op_i == OP_LOAD && load_ok) begin
      adj_mem[vertex_i[IW-1:0]] <= row_edges_i[VERTICES-1:0];
    end

    case (state_q)
      ST_ROOT: begin
        if (!root_done && !visited_q[root_idx]) begin
          cur_v_q            <= root_idx;
          cur_k_q            <= '0;
          cur_num_q          <= vcnt_q;
          cur_low_q          <= vcnt_q;
          vnum_mem[root_idx] <= vcnt_q;
          cstk_mem[ctop_idx] <= root_idx;
        end
      end
      ST_ROWRD: begin
        row_q     <= adj_mem[cur_v_q];
        row_vld_q <= adj_vld_q[cur_v_q];
      end
      ST_SCAN: begin
        vnum_rd_q <= vnum_mem[k_idx];
        if (!scan_done) begin
          if (edge_bit && !visited_q[k_idx]) begin
            // Save the caller frame, then enter the neighbor
            fstk_mem[ftop_idx] <= '{v: cur_v_q, k: cur_k_inc, num: cur_num_q,
                                    low: cur_low_q};
            cur_v_q            <= k_idx;
            cur_k_q            <= '0;
            cur_num_q          <= vcnt_q;
            cur_low_q          <= vcnt_q;
            vnum_mem[k_idx]    <= vcnt_q;
            cstk_mem[ctop_idx] <= k_idx;
          end else begin
            cur_k_q <= cur_k_inc;
          end
        end
      end
      ST_NUMCMP: begin
        if (vnum_rd_q < cur_low_q) begin
          cur_low_q <= vnum_rd_q;
        end
      end
      ST_POPRD: begin
        cstk_rd_q <= cstk_mem[ctop_m1[IW-1:0]];
      end
      ST_POPOUT: begin
        if (out_free) begin
          member_q   <= vertex_t'(cstk_rd_q);
          comp_out_q <= comp_q;
          closes_q   <= (cstk_rd_q == cur_v_q);
          last_q     <= (emit_q == KW'(VERTICES - 1));
        end
      end
      ST_RET: begin
        frame_rd_q <= fstk_mem[ftop_m1[IW-1:0]];
      end
      ST_RESTORE: begin
        // Resume the caller and fold in the child's low link
        cur_v_q   <= frame_rd_q.v;
        cur_k_q   <= frame_rd_q.k;
        cur_num_q <= frame_rd_q.num;
        cur_low_q <= (cur_low_q < frame_rd_q.low) ? cur_low_q : frame_rd_q.low;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o        = out_valid_q;
  assign member_o           = member_q;
  assign component_o        = comp_out_q;
  assign closes_component_o = closes_q;
  assign last_o             = last_q;

`ifndef ASSERT_OFF
  // Caller frames never outnumber vertices on the component stack
  a_frames_le_stack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ftop_q <= ctop_q)
    else $error("call frames exceed component stack depth");

  // While scanning, on-stack marks match the component stack depth
  a_onstk_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ($countones(onstk_q) == int'(ctop_q)))
    else $error("on-stack marks out of step with component stack");

  // The final beat of a run always closes a component
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> closes_component_o)
    else $error("last beat does not close a component");
`endif

endmodule

`default_nettype wire

>>> sim/tb_strongly_connected_components_core.sv
// ----------------------------------------------------------------------------
// tb_strongly_connected_components_core
// Self-checking bench for the Tarjan component search core.
// ----------------------------------------------------------------------------
// Loads adjacency rows and starts searches. A behavioral copy of the search
// predicts every member beat of each run. Monitored beats are compared in
// order against those predictions. Both sides insert random gaps and stalls.
`default_nettype none

module tb_strongly_connected_components_core;
  import scc_pkg::*;

  localparam int NumV        = 64;
  localparam int StallLimit  = 50000;
  localparam int RandomItems = 245;

  typedef struct packed {
    vertex_t member;
    comp_t   component;
    logic    closes;
    logic    last;
  } member_beat_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid_i = 1'b0;
  logic    in_stall_o;
  op_e     op_i = OP_LOAD;
  vertex_t vertex_i = '0;
  row_t    row_edges_i = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  vertex_t member_o;
  comp_t   component_o;
  logic    closes_component_o;
  logic    last_o;

  // Predictor state: the graph as the core should hold it
  row_t         graph_rows [NumV];
  member_beat_t pending_members [$];
  int           mismatches = 0;
  int           loads_sent = 0;
  int           searches_sent = 0;
  int           beats_checked = 0;
  bit           no_idle = 1'b0;
  int           quiet_cycles = 0;

  strongly_connected_components_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i, .vertex_i, .row_edges_i,
    .out_valid_o, .out_stall_i, .member_o, .component_o, .closes_component_o,
    .last_o
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predict the member beats of one component search over graph_rows
  task automatic predict_search();
    int vnum [NumV];
    int low [NumV];
    bit onstk [NumV];
    int comp_stack [NumV];
    int call_v [NumV];
    int call_k [NumV];
    int comp_top, call_top, counter, comp_no, v, k, w;
    member_beat_t beats [$];
    member_beat_t b;
    comp_top = 0;
    call_top = 0;
    counter  = 0;
    comp_no  = 1;
    for (int i = 0; i < NumV; i++) begin
      vnum[i]  = -1;
      onstk[i] = 1'b0;
    end
    for (int root = 0; root < NumV; root++) begin
      if (vnum[root] >= 0) continue;
      vnum[root] = counter; low[root] = counter; counter++;
      comp_stack[comp_top++] = root; onstk[root] = 1'b1;
      call_v[call_top] = root; call_k[call_top] = 0; call_top++;
      while (call_top > 0) begin
        v = call_v[call_top-1];
        k = call_k[call_top-1];
        if (k >= NumV) begin
          // Scan done: close a component if v is its root, then return
          call_top--;
          if (low[v] == vnum[v]) begin
            do begin
              w = comp_stack[--comp_top];
              onstk[w] = 1'b0;
              b.member = vertex_t'(w);
              b.component = comp_t'(comp_no);
              b.closes = (w == v);
              b.last = 1'b0;
              beats.push_back(b);
            end while (w != v);
            comp_no++;
          end
          if (call_top > 0 && low[v] < low[call_v[call_top-1]])
            low[call_v[call_top-1]] = low[v];
          continue;
        end
        call_k[call_top-1] = k + 1;
        if (graph_rows[v][k]) begin
          if (vnum[k] < 0) begin
            vnum[k] = counter; low[k] = counter; counter++;
            comp_stack[comp_top++] = k; onstk[k] = 1'b1;
            call_v[call_top] = k; call_k[call_top] = 0; call_top++;
          end else if (onstk[k] && vnum[k] < low[v]) begin
            low[v] = vnum[k];
          end
        end
      end
    end
    beats[beats.size()-1].last = 1'b1;
    foreach (beats[i]) pending_members.push_back(beats[i]);
  endtask

  // Send one beat after a random gap; valid stays high if the next gap is 0
  task automatic send_item(input op_e op, input vertex_t vtx, input row_t row);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    vertex_i    <= vtx;
    row_edges_i <= row;
    do @(posedge clk_i); while (in_stall_o);
    if (op == OP_LOAD) begin
      graph_rows[vtx] = row;
      loads_sent++;
    end else begin
      predict_search();
      searches_sent++;
    end
  endtask

  task automatic load_row(input int vtx, input row_t row);
    send_item(OP_LOAD, vertex_t'(vtx), row);
  endtask

  task automatic start_search();
    send_item(OP_RUN, vertex_t'($urandom_range(0, 63)), {$urandom, $urandom});
  endtask

  // Drop valid and hold off until every predicted beat has been seen
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_members.size() != 0);
  endtask

  // Random row: mostly sparse so components of several sizes form
  function automatic row_t random_row();
    row_t r;
    int   kind;
    r = '0;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      repeat ($urandom_range(0, 3)) r[$urandom_range(0, 63)] = 1'b1;
    end else if (kind < 9) begin
      r = {$urandom, $urandom};
    end
    return r;
  endfunction

  // Empty graph: every vertex is its own component
  task automatic test_empty_graph();
    start_search();
    wait_drained();
  endtask

  // Full rows with self loops on a few vertices: those merge into one component
  task automatic test_complete_graph();
    load_row(63, '1);
    for (int i = 0; i < 6; i++) load_row(i * 12, '1);
    start_search();
    // Clear back to an empty graph
    load_row(63, '0);
    for (int i = 0; i < 6; i++) load_row(i * 12, '0);
  endtask

  // Ring over low vertices, a self loop, and a second ring (10, 11, 63) with an edge out to 12
  task automatic test_ring_and_chain();
    no_idle = 1'b1;
    load_row(0, row_t'(1) << 1);
    load_row(1, row_t'(1) << 2);
    load_row(2, row_t'(1));
    load_row(5, row_t'(1) << 5);
    load_row(10, row_t'(1) << 11);
    load_row(11, (row_t'(1) << 12) | (row_t'(1) << 63));
    load_row(63, row_t'(1) << 10);
    no_idle = 1'b0;
    start_search();
    start_search();
  endtask

  // Random graphs with searches scattered among the loads
  task automatic test_random_graphs();
    for (int n = 0; n < RandomItems; n++) begin
      no_idle = ((n / 40) % 3 == 2);
      if (n == RandomItems / 2) wait_drained();
      if ($urandom_range(0, 7) == 0) start_search();
      else load_row($urandom_range(0, 63), random_row());
    end
    start_search();
  endtask

  // Result side: random stall per beat, then compare with the oldest prediction
  initial begin
    int           hold;
    member_beat_t exp_b;
    @(posedge rst_ni);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
      beats_checked++;
      if (pending_members.size() == 0) begin
        $display("%0t: unexpected beat member=%0d component=%0d", $time, member_o,
                 component_o);
        mismatches++;
      end else begin
        exp_b = pending_members.pop_front();
        if (member_o !== exp_b.member || component_o !== exp_b.component ||
            closes_component_o !== exp_b.closes || last_o !== exp_b.last) begin
          $display("%0t: mismatch exp member=%0d comp=%0d closes=%0b last=%0b",
                   $time, exp_b.member, exp_b.component, exp_b.closes, exp_b.last);
          $display("%0t:          got member=%0d comp=%0d closes=%0b last=%0b",
                   $time, member_o, component_o, closes_component_o, last_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: abort when no beat moves on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: timeout, %0d beats still expected", $time,
                 pending_members.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    foreach (graph_rows[i]) graph_rows[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_graph();
    test_complete_graph();
    test_ring_and_chain();
    test_random_graphs();
    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("Covered %0d row loads and %0d searches, %0d member beats checked.",
             loads_sent, searches_sent, beats_checked);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
